>>> design/ncp_pkg.sv
// Package for the normalized cross product block: item types, fixed widths,
// the data carried down the cell chains and the output saturation helper.
// Depends on nothing.
`default_nettype none

package ncp_pkg;

    // Input item: two Q2.14 vectors
    typedef struct packed {
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic signed [15:0] first_z;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
        logic signed [15:0] second_z;
    } ncp_in_t;

    // Result item: unit vector and found flag
    typedef struct packed {
        logic signed [15:0] unit_x;
        logic signed [15:0] unit_y;
        logic signed [15:0] unit_z;
        logic               found;
    } ncp_out_t;

    localparam int SUM_W  = 64;   // squared length
    localparam int ROOT_W = 32;   // integer square root
    localparam int SQ_RW  = 36;   // square root remainder
    localparam int MAG_W  = 32;   // absolute cross component
    localparam int DIV_DW = 33;   // divisor, twice the length
    localparam int DIV_RW = 35;   // divider remainder

    // Control carried beside the divider lanes
    typedef struct packed {
        logic [2:0] neg;    // negate lane x, y, z
        logic       zero;   // zero-length product
    } ncp_dctl_t;

    // Data carried along the square root cells
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;   // |cx|, |cy|, |cz|
        ncp_dctl_t             ctl;
    } ncp_carry_t;

    // Apply sign and clamp a quotient magnitude to 16-bit signed
    function automatic logic signed [15:0] sat_unit(input logic [31:0] mag,
                                                    input logic neg);
        logic signed [15:0] res;
        if (neg) begin
            if (mag > 32'd32768)
                res = 16'sh8000;
            else
                res = 16'(32'd0 - mag);
        end
        else begin
            if (mag > 32'd32767)
                res = 16'sh7fff;
            else
                res = 16'(mag);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> design/ncp_sqrt_cell.sv
// One square root chain cell: retires two bits of the squared length
// per cycle while en is high; hands root, remainder and payload onward.
// Depends on ncp_pkg.
`default_nettype none

module ncp_sqrt_cell #(
    parameter int IDX = 0
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [ncp_pkg::SUM_W-1:0]  in_s,
    input  wire logic [ncp_pkg::SQ_RW-1:0]  in_rem,
    input  wire logic [ncp_pkg::ROOT_W-1:0] in_root,
    input  wire ncp_pkg::ncp_carry_t        in_carry,
    output logic                            out_valid,
    output logic [ncp_pkg::SUM_W-1:0]       out_s,
    output logic [ncp_pkg::SQ_RW-1:0]       out_rem,
    output logic [ncp_pkg::ROOT_W-1:0]      out_root,
    output ncp_pkg::ncp_carry_t             out_carry
);
    import ncp_pkg::*;

    logic                valid_reg;
    logic [SUM_W-1:0]    s_reg;
    logic [SQ_RW-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    ncp_carry_t          carry_reg;
    logic [SQ_RW-1:0]    rem_sh;
    logic [SQ_RW-1:0]    trial;

    // Bring down two bits and try subtracting 4*root+1
    always_comb
    begin
        rem_sh = {in_rem[SQ_RW-3:0], in_s[SUM_W-1-2*IDX -: 2]};
        trial  = {(SQ_RW-ROOT_W-2)'(0), in_root, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = {in_root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {in_root[ROOT_W-2:0], 1'b0};
        end
    end

    // Advance valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg     <= in_s;
            rem_reg   <= rem_next;
            root_reg  <= root_next;
            carry_reg <= in_carry;
        end
    end

    assign out_valid = valid_reg;
    assign out_s     = s_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_carry = carry_reg;

endmodule

`default_nettype wire

>>> design/ncp_div_cell.sv
// One divider chain cell: one restoring quotient bit per cycle, while en
// is high, for each of the three components, sharing one divisor.
// Depends on ncp_pkg.
`default_nettype none

module ncp_div_cell #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  wire logic                                  in_valid,
    input  wire logic [ncp_pkg::DIV_DW-1:0]            in_d,
    input  wire logic [2:0][ncp_pkg::DIV_RW-1:0]       in_rem,
    input  wire logic [2:0][FRAC_BITS:0]               in_qn,
    input  wire ncp_pkg::ncp_dctl_t                    in_ctl,
    output logic                                       out_valid,
    output logic [ncp_pkg::DIV_DW-1:0]                 out_d,
    output logic [2:0][ncp_pkg::DIV_RW-1:0]            out_rem,
    output logic [2:0][FRAC_BITS:0]                    out_qn,
    output ncp_pkg::ncp_dctl_t                         out_ctl
);
    import ncp_pkg::*;

    localparam int QW = FRAC_BITS + 1;

    logic                     valid_reg;
    logic [DIV_DW-1:0]        d_reg;
    logic [2:0][DIV_RW-1:0]   rem_reg, rem_next;
    logic [2:0][QW-1:0]       qn_reg, qn_next;
    ncp_dctl_t                ctl_reg;
    logic [2:0][DIV_RW-1:0]   rem_sh;
    logic [2:0]               ge;

    // Shift in the next numerator bit, subtract when it fits
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem_sh[i]   = {in_rem[i][DIV_RW-2:0], in_qn[i][QW-1]};
            ge[i]       = rem_sh[i] >= DIV_RW'(in_d);
            rem_next[i] = ge[i] ? rem_sh[i] - DIV_RW'(in_d) : rem_sh[i];
            qn_next[i]  = {in_qn[i][QW-2:0], ge[i]};
        end
    end

    // Advance valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg   <= in_d;
            rem_reg <= rem_next;
            qn_reg  <= qn_next;
            ctl_reg <= in_ctl;
        end
    end

    assign out_valid = valid_reg;
    assign out_d     = d_reg;
    assign out_rem   = rem_reg;
    assign out_qn    = qn_reg;
    assign out_ctl   = ctl_reg;

endmodule

`default_nettype wire

>>> design/normalized_cross_product_up.sv
// Top level of the normalized cross product: cross and square stages, a
// chain of square root cells, a chain of divider cells and an output buffer.
// Depends on ncp_pkg, ncp_sqrt_cell and ncp_div_cell.
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  input    | in_valid, in_stall, in_data      | in
//  result   | out_valid, out_stall, out_data   | out
//  config   | cfg_write, cfg_wdata (up_mode)   | in
//
// One item enters per cycle while in_stall is low; on its way to the output
// register it passes four cross/square/sum stages, 32 square root cells,
// one divider setup stage and FRAC_BITS + 1 divider cells.
// Reset clears all valid bits and sets up_mode to 1.
// The output holds one item plus one skid entry; in_stall rises only while
// the skid entry is occupied, and then the whole chain holds.
`default_nettype none

module normalized_cross_product_up #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire ncp_pkg::ncp_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output ncp_pkg::ncp_out_t      out_data,
    input  wire logic              cfg_write,
    input  wire logic              cfg_wdata
);
    import ncp_pkg::*;

    localparam int QW = FRAC_BITS + 1;

    logic en;
    logic up_mode_reg;

    // Stage A: six products
    logic                     a_v_reg;
    logic signed [31:0]       p_reg [6];
    // Stage B: magnitudes and control
    logic                     b_v_reg;
    logic [2:0][MAG_W-1:0]    b_mag_reg;
    ncp_dctl_t                b_ctl_reg;
    // Stage C: squares
    logic                     c_v_reg;
    logic [SUM_W-1:0]         sq_reg [3];
    ncp_carry_t               c_carry_reg;
    // Stage D: sum
    logic                     d_v_reg;
    logic [SUM_W-1:0]         d_s_reg;
    ncp_carry_t               d_carry_reg;
    // Stage E: divider setup
    logic                     e_v_reg;
    logic [DIV_DW-1:0]        e_d_reg;
    logic [2:0][DIV_RW-1:0]   e_rem_reg;
    logic [2:0][QW-1:0]       e_qn_reg;
    ncp_dctl_t                e_ctl_reg;

    logic signed [32:0]       cc [3];
    ncp_dctl_t                b_ctl_next;
    logic                     flip;

    // Chain links
    logic                     sq_v    [ROOT_W+1];
    logic [SUM_W-1:0]         sq_s    [ROOT_W+1];
    logic [SQ_RW-1:0]         sq_rem  [ROOT_W+1];
    logic [ROOT_W-1:0]        sq_root [ROOT_W+1];
    ncp_carry_t               sq_carry[ROOT_W+1];

    logic                     dv_v   [QW+1];
    logic [DIV_DW-1:0]        dv_d   [QW+1];
    logic [2:0][DIV_RW-1:0]   dv_rem [QW+1];
    logic [2:0][QW-1:0]       dv_qn  [QW+1];
    ncp_dctl_t                dv_ctl [QW+1];

    // Output buffer
    logic      main_v_reg, skid_v_reg;
    ncp_out_t  main_reg, skid_reg;
    ncp_out_t  res;
    logic      push, pop;

    assign en       = !skid_v_reg;
    assign in_stall = skid_v_reg;

    // Hold the orientation register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            up_mode_reg <= 1'b1;
        else if (cfg_write)
            up_mode_reg <= cfg_wdata;
    end

    // Form cross components and orientation flags
    always_comb
    begin
        cc[0] = 33'(p_reg[0]) - 33'(p_reg[1]);
        cc[1] = 33'(p_reg[2]) - 33'(p_reg[3]);
        cc[2] = 33'(p_reg[4]) - 33'(p_reg[5]);
        flip  = up_mode_reg && (cc[2][32] || cc[2] == 33'sd0);
        for (int i = 0; i < 3; i++)
            b_ctl_next.neg[i] = cc[i][32] ^ flip;
        b_ctl_next.zero = (cc[0] == 33'sd0) && (cc[1] == 33'sd0) && (cc[2] == 33'sd0);
    end

    // Advance front stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= sq_v[ROOT_W];
        end
    end

    // Advance front stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= 32'(in_data.first_y) * 32'(in_data.second_z);
            p_reg[1] <= 32'(in_data.first_z) * 32'(in_data.second_y);
            p_reg[2] <= 32'(in_data.first_z) * 32'(in_data.second_x);
            p_reg[3] <= 32'(in_data.first_x) * 32'(in_data.second_z);
            p_reg[4] <= 32'(in_data.first_x) * 32'(in_data.second_y);
            p_reg[5] <= 32'(in_data.first_y) * 32'(in_data.second_x);
            for (int i = 0; i < 3; i++)
                b_mag_reg[i] <= cc[i][32] ? MAG_W'(33'sd0 - cc[i]) : MAG_W'(cc[i]);
            b_ctl_reg <= b_ctl_next;
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= SUM_W'(b_mag_reg[i]) * SUM_W'(b_mag_reg[i]);
            c_carry_reg.mag <= b_mag_reg;
            c_carry_reg.ctl <= b_ctl_reg;
            d_s_reg     <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            d_carry_reg <= c_carry_reg;
            // Divider setup: numerator top is |c| + (m >> (F+1))
            e_d_reg <= {sq_root[ROOT_W], 1'b0};
            for (int i = 0; i < 3; i++)
            begin
                e_rem_reg[i] <= DIV_RW'(sq_carry[ROOT_W].mag[i])
                              + DIV_RW'(sq_root[ROOT_W] >> QW);
                e_qn_reg[i]  <= sq_root[ROOT_W][QW-1:0];
            end
            e_ctl_reg <= sq_carry[ROOT_W].ctl;
        end
    end

    // Square root chain
    assign sq_v[0]     = d_v_reg;
    assign sq_s[0]     = d_s_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_carry[0] = d_carry_reg;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        ncp_sqrt_cell #(.IDX(k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_v[k]),
            .in_s      (sq_s[k]),
            .in_rem    (sq_rem[k]),
            .in_root   (sq_root[k]),
            .in_carry  (sq_carry[k]),
            .out_valid (sq_v[k+1]),
            .out_s     (sq_s[k+1]),
            .out_rem   (sq_rem[k+1]),
            .out_root  (sq_root[k+1]),
            .out_carry (sq_carry[k+1])
        );
    end

    // Divider chain
    assign dv_v[0]   = e_v_reg;
    assign dv_d[0]   = e_d_reg;
    assign dv_rem[0] = e_rem_reg;
    assign dv_qn[0]  = e_qn_reg;
    assign dv_ctl[0] = e_ctl_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        ncp_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_v[k]),
            .in_d      (dv_d[k]),
            .in_rem    (dv_rem[k]),
            .in_qn     (dv_qn[k]),
            .in_ctl    (dv_ctl[k]),
            .out_valid (dv_v[k+1]),
            .out_d     (dv_d[k+1]),
            .out_rem   (dv_rem[k+1]),
            .out_qn    (dv_qn[k+1]),
            .out_ctl   (dv_ctl[k+1])
        );
    end

    // Sign and saturate; zero-length results give zeros with found low
    always_comb
    begin
        if (dv_ctl[QW].zero)
        begin
            res = '0;
        end
        else
        begin
            res.unit_x = sat_unit(32'(dv_qn[QW][0]), dv_ctl[QW].neg[0]);
            res.unit_y = sat_unit(32'(dv_qn[QW][1]), dv_ctl[QW].neg[1]);
            res.unit_z = sat_unit(32'(dv_qn[QW][2]), dv_ctl[QW].neg[2]);
            res.found  = 1'b1;
        end
    end

    assign push = dv_v[QW] && en;
    assign pop  = main_v_reg && !out_stall;

    // Output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (pop)
        begin
            main_v_reg <= skid_v_reg || push;
            skid_v_reg <= 1'b0;
        end
        else if (!main_v_reg)
        begin
            main_v_reg <= push;
        end
        else if (push)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            main_reg <= skid_v_reg ? skid_reg : res;
        else if (!main_v_reg)
            main_reg <= res;
        else if (push)
            skid_reg <= res;
    end

    assign out_valid = main_v_reg;
    assign out_data  = main_reg;

    // Skid entry only ever fills behind a held result
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> main_v_reg)
        else $error("skid entry valid without main entry");

    // Zero-length results carry zeros
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.found) |->
        (out_data.unit_x == 16'sd0 && out_data.unit_y == 16'sd0 &&
         out_data.unit_z == 16'sd0))
        else $error("not-found result with nonzero components");

    // A found unit vector is never all zeros
    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.found) |->
        (out_data.unit_x != 16'sd0 || out_data.unit_y != 16'sd0 ||
         out_data.unit_z != 16'sd0))
        else $error("found result is a zero vector");

endmodule

`default_nettype wire
